// File: hdl/sbf_pkg.sv
// Package: result record type and fixed field widths of the subset-sum search.
`timescale 1ns / 1ps

package sbf_pkg;

    // fixed port field widths
    localparam int INDEX_W = 4;
    localparam int LIMIT_W = 20;
    localparam int IN_W    = 16;

    // one result beat
    typedef struct packed {
        logic [INDEX_W-1:0] item_index;
        logic [LIMIT_W-1:0] best_sum;
        logic               none_chosen;
        logic               too_many;
        logic               last_result;
    } result_t;

endpackage

// File: hdl/sbf_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sbf_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/sbf_out.sv
// Output register stage: holds one result beat until the sink takes it.
`timescale 1ns / 1ps

module sbf_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sbf_pkg::result_t rec,
    input  logic             out_stall,
    output logic             out_valid,
    output sbf_pkg::result_t rec_out,
    output logic             free
);

    logic             valid_reg;
    logic             valid_next;
    sbf_pkg::result_t rec_reg;

    // slot is free when empty or being drained this cycle
    assign free       = !valid_reg || !out_stall;
    assign valid_next = load ? 1'b1 : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec;
        end
    end

    assign out_valid = valid_reg;
    assign rec_out   = rec_reg;

endmodule

// File: hdl/subset_sum_best_fit_search.sv
// Subset-sum best-fit search: top level with load, sort, bound and search sequencer.
// Weights load at one beat per cycle into a weight RAM; the beat with last_item
// starts a run and the input stalls until the run's last result beat is queued.
// A run over the stored weights ranks them into a sorted RAM (one weight RAM
// read per compare), then runs the largest-first bound scan and the search,
// which walks every nonempty subset as a bit mask and sums it with one weight
// RAM read per item. Results then leave at up to one beat per cycle, one per
// chosen item in ascending index order, or a single none_chosen beat.
// Weights beyond MAX_ITEMS are dropped and reported on too_many.
`timescale 1ns / 1ps

module subset_sum_best_fit_search #(
    parameter int MAX_ITEMS   = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         mass_limit_we,
    input  logic [sbf_pkg::LIMIT_W-1:0]  mass_limit,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [sbf_pkg::IN_W-1:0]     weight,
    input  logic                         last_item,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sbf_pkg::INDEX_W-1:0]  item_index,
    output logic [sbf_pkg::LIMIT_W-1:0]  best_sum,
    output logic                         none_chosen,
    output logic                         too_many,
    output logic                         last_result
);

    localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int RAW_W  = WEIGHT_BITS + CNT_W;
    localparam int SUM_W  = (RAW_W > sbf_pkg::LIMIT_W) ? RAW_W : sbf_pkg::LIMIT_W;
    localparam int MASK_W = MAX_ITEMS;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RK_A = 3'd1;
    localparam logic [2:0] S_RK_B = 3'd2;
    localparam logic [2:0] S_RK_C = 3'd3;
    localparam logic [2:0] S_LOW  = 3'd4;
    localparam logic [2:0] S_SRCH = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // registers
    logic [2:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       drop_reg, drop_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic                       drop_run_reg, drop_run_next;
    logic [sbf_pkg::LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]           i_reg, i_next;
    logic [CNT_W-1:0]           j_reg, j_next;
    logic [WEIGHT_BITS-1:0]     wi_reg, wi_next;
    logic [CNT_W-1:0]           rank_reg, rank_next;
    logic                       p_valid_reg, p_valid_next;
    logic [IDX_W-1:0]           p_j_reg, p_j_next;
    logic [SUM_W-1:0]           acc_reg, acc_next;
    logic [CNT_W-1:0]           pop_reg, pop_next;
    logic [CNT_W-1:0]           lower_reg, lower_next;
    logic [MASK_W-1:0]          mask_reg, mask_next;
    logic [MASK_W-1:0]          best_mask_reg, best_mask_next;
    logic [SUM_W-1:0]           best_sum_reg, best_sum_next;
    logic [CNT_W-1:0]           best_pop_reg, best_pop_next;
    logic                       found_reg, found_next;
    logic [IDX_W-1:0]           o_idx_reg, o_idx_next;
    logic [MASK_W-1:0]          rem_reg, rem_next;

    // datapath
    logic                       in_acc;
    logic                       item_we;
    logic [IDX_W-1:0]           item_raddr;
    logic [WEIGHT_BITS-1:0]     item_rdata;
    logic                       sort_we;
    logic [IDX_W-1:0]           sort_raddr;
    logic [WEIGHT_BITS-1:0]     sort_rdata;
    logic                       issue;
    logic                       hit;
    logic [CNT_W-1:0]           rank_inc;
    logic [IDX_W-1:0]           last_j;
    logic [SUM_W-1:0]           limit_ext;
    logic [SUM_W-1:0]           low_try;
    logic                       mbit;
    logic [SUM_W-1:0]           sum_fin;
    logic [CNT_W-1:0]           pop_fin;
    logic                       better;
    logic [MASK_W:0]            one_sh;
    logic [MASK_W-1:0]          full_mask;
    logic [MASK_W-1:0]          rem_clr;
    logic                       out_load;
    logic                       out_free;
    sbf_pkg::result_t           out_rec;
    sbf_pkg::result_t           rec_q;

    // bit reverse so that a larger value means earlier in lexicographic order
    function automatic logic [MASK_W-1:0] rev_mask(input logic [MASK_W-1:0] m);
        logic [MASK_W-1:0] r;
        for (int b = 0; b < MASK_W; b++)
        begin
            r[b] = m[MASK_W-1-b];
        end
        return r;
    endfunction

    sbf_ram #(.DEPTH(MAX_ITEMS), .WIDTH(WEIGHT_BITS)) u_item_ram (
        .clk   (clk),
        .we    (item_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (WEIGHT_BITS'(weight)),
        .raddr (item_raddr),
        .rdata (item_rdata)
    );

    sbf_ram #(.DEPTH(MAX_ITEMS), .WIDTH(WEIGHT_BITS)) u_sort_ram (
        .clk   (clk),
        .we    (sort_we),
        .waddr (rank_inc[IDX_W-1:0]),
        .wdata (wi_reg),
        .raddr (sort_raddr),
        .rdata (sort_rdata)
    );

    sbf_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .rec       (out_rec),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .rec_out   (rec_q),
        .free      (out_free)
    );

    assign item_index  = rec_q.item_index;
    assign best_sum    = rec_q.best_sum;
    assign none_chosen = rec_q.none_chosen;
    assign too_many    = rec_q.too_many;
    assign last_result = rec_q.last_result;

    // input side
    assign in_stall = (state_reg != S_LOAD);
    assign in_acc   = in_valid && !in_stall;
    assign item_we  = in_acc && (cnt_reg < CNT_W'(MAX_ITEMS));

    // read scheduling and compare datapath
    assign last_j    = IDX_W'(n_reg - CNT_W'(1));
    assign limit_ext = SUM_W'(limit_reg);
    assign item_raddr = (state_reg == S_RK_A) ? i_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];
    assign sort_raddr = IDX_W'(j_reg - CNT_W'(1));

    always_comb
    begin
        case (state_reg)
            S_RK_C, S_SRCH: issue = (j_reg < n_reg);
            S_LOW:          issue = (j_reg != '0);
            default:        issue = 1'b0;
        endcase
    end

    assign hit = (item_rdata < wi_reg) ||
                 ((item_rdata == wi_reg) && (CNT_W'(p_j_reg) < i_reg));
    assign rank_inc = rank_reg + CNT_W'(hit);
    assign sort_we  = (state_reg == S_RK_C) && p_valid_reg && (p_j_reg == last_j);

    assign low_try = acc_reg + SUM_W'(sort_rdata);
    assign mbit    = mask_reg[p_j_reg];
    assign sum_fin = acc_reg + (mbit ? SUM_W'(item_rdata) : '0);
    assign pop_fin = pop_reg + CNT_W'(mbit);

    // candidate ordering: larger sum, then fewer items, then lexicographically first
    assign better = (pop_fin >= lower_reg) && (sum_fin <= limit_ext) &&
                    (sum_fin != '0) &&
                    ((sum_fin > best_sum_reg) ||
                     ((sum_fin == best_sum_reg) &&
                      ((pop_fin < best_pop_reg) ||
                       ((pop_fin == best_pop_reg) &&
                        (rev_mask(mask_reg) > rev_mask(best_mask_reg))))));

    assign one_sh    = (MASK_W + 1)'(1) << n_reg;
    assign full_mask = MASK_W'(one_sh - (MASK_W + 1)'(1));
    assign rem_clr   = rem_reg & ~(MASK_W'(1) << o_idx_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        drop_next      = drop_reg;
        n_next         = n_reg;
        drop_run_next  = drop_run_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        wi_next        = wi_reg;
        rank_next      = rank_reg;
        p_valid_next   = issue;
        p_j_next       = (state_reg == S_LOW) ? sort_raddr : j_reg[IDX_W-1:0];
        acc_next       = acc_reg;
        pop_next       = pop_reg;
        lower_next     = lower_reg;
        mask_next      = mask_reg;
        best_mask_next = best_mask_reg;
        best_sum_next  = best_sum_reg;
        best_pop_next  = best_pop_reg;
        found_next     = found_reg;
        o_idx_next     = o_idx_reg;
        rem_next       = rem_reg;
        out_load       = 1'b0;
        out_rec        = '0;

        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (item_we)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (last_item)
                    begin
                        n_next         = item_we ? (cnt_reg + CNT_W'(1)) : cnt_reg;
                        drop_run_next  = drop_reg || !item_we;
                        cnt_next       = '0;
                        drop_next      = 1'b0;
                        i_next         = '0;
                        best_mask_next = '0;
                        best_sum_next  = '0;
                        best_pop_next  = '0;
                        found_next     = 1'b0;
                        state_next     = S_RK_A;
                    end
                end
            end

            S_RK_A:
            begin
                state_next = S_RK_B;
            end

            S_RK_B:
            begin
                wi_next    = item_rdata;
                j_next     = '0;
                rank_next  = '0;
                state_next = S_RK_C;
            end

            // count smaller weights (ties by index) to find this weight's slot
            S_RK_C:
            begin
                if (issue)
                begin
                    j_next = j_reg + CNT_W'(1);
                end
                if (p_valid_reg)
                begin
                    rank_next = rank_inc;
                    if (p_j_reg == last_j)
                    begin
                        i_next = i_reg + CNT_W'(1);
                        if (i_reg + CNT_W'(1) == n_reg)
                        begin
                            j_next     = n_reg;
                            acc_next   = '0;
                            pop_next   = '0;
                            state_next = S_LOW;
                        end
                        else
                        begin
                            state_next = S_RK_A;
                        end
                    end
                end
            end

            // greedy largest-first count gives the smallest size tried
            S_LOW:
            begin
                if (issue)
                begin
                    j_next = j_reg - CNT_W'(1);
                end
                if (p_valid_reg)
                begin
                    if (low_try <= limit_ext)
                    begin
                        acc_next = low_try;
                        pop_next = pop_reg + CNT_W'(1);
                    end
                    if (p_j_reg == '0)
                    begin
                        if (low_try <= limit_ext)
                        begin
                            lower_next = pop_reg + CNT_W'(1);
                        end
                        else
                        begin
                            lower_next = (pop_reg == '0) ? CNT_W'(1) : pop_reg;
                        end
                        mask_next  = MASK_W'(1);
                        j_next     = '0;
                        acc_next   = '0;
                        pop_next   = '0;
                        state_next = S_SRCH;
                    end
                end
            end

            // sum one subset per pass, keep the best
            S_SRCH:
            begin
                if (issue)
                begin
                    j_next = j_reg + CNT_W'(1);
                end
                if (p_valid_reg)
                begin
                    acc_next = sum_fin;
                    pop_next = pop_fin;
                    if (p_j_reg == last_j)
                    begin
                        if (better)
                        begin
                            best_mask_next = mask_reg;
                            best_sum_next  = sum_fin;
                            best_pop_next  = pop_fin;
                            found_next     = 1'b1;
                        end
                        j_next   = '0;
                        acc_next = '0;
                        pop_next = '0;
                        if (mask_reg == full_mask)
                        begin
                            rem_next   = better ? mask_reg : best_mask_reg;
                            o_idx_next = '0;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            mask_next = mask_reg + MASK_W'(1);
                        end
                    end
                end
            end

            // one beat per chosen item, ascending index, or a single none_chosen beat
            S_OUT:
            begin
                if (!found_reg)
                begin
                    if (out_free)
                    begin
                        out_load            = 1'b1;
                        out_rec.none_chosen = 1'b1;
                        out_rec.too_many    = drop_run_reg;
                        out_rec.last_result = 1'b1;
                        state_next          = S_LOAD;
                    end
                end
                else if (!rem_reg[o_idx_reg])
                begin
                    o_idx_next = o_idx_reg + IDX_W'(1);
                end
                else if (out_free)
                begin
                    out_load            = 1'b1;
                    out_rec.item_index  = sbf_pkg::INDEX_W'(o_idx_reg);
                    out_rec.best_sum    = sbf_pkg::LIMIT_W'(best_sum_reg);
                    out_rec.too_many    = drop_run_reg;
                    out_rec.last_result = (rem_clr == '0);
                    rem_next            = rem_clr;
                    o_idx_next          = o_idx_reg + IDX_W'(1);
                    if (rem_clr == '0)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            cnt_reg     <= '0;
            drop_reg    <= 1'b0;
            limit_reg   <= '0;
            p_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            drop_reg    <= drop_next;
            p_valid_reg <= p_valid_next;
            found_reg   <= found_next;
            if (mass_limit_we)
            begin
                limit_reg <= mass_limit;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        drop_run_reg  <= drop_run_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        wi_reg        <= wi_next;
        rank_reg      <= rank_next;
        p_j_reg       <= p_j_next;
        acc_reg       <= acc_next;
        pop_reg       <= pop_next;
        lower_reg     <= lower_next;
        mask_reg      <= mask_next;
        best_mask_reg <= best_mask_next;
        best_sum_reg  <= best_sum_next;
        best_pop_reg  <= best_pop_next;
        o_idx_reg     <= o_idx_next;
        rem_reg       <= rem_next;
    end

    // checks
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_OUT)
        else $error("result beat appeared outside the emit phase");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ITEMS))
        else $error("stored item count exceeds capacity");

    a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && found_reg) |-> (best_sum_reg <= limit_ext && best_sum_reg != '0))
        else $error("chosen sum violates the limit or is zero");

    a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) |-> (mask_reg != '0))
        else $error("search mask is empty");

    a_stall_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && last_item) |=> in_stall)
        else $error("input taken while a run starts");

endmodule

// File: tb/sv/tb_subset_sum_best_fit_search.sv
// Testbench for the subset-sum best-fit search: directed table, random sets, self-checking.
`timescale 1ns / 1ps

module tb_subset_sum_best_fit_search;

    localparam int CAP        = 16;
    localparam int HANG_LIMIT = 6000000;
    localparam int LONG_HOLD  = 400;

    typedef struct {
        bit                          cfg;
        logic [sbf_pkg::LIMIT_W-1:0] lim;
        logic [sbf_pkg::IN_W-1:0]    w;
        bit                          l;
        bit                          typed;
        sbf_pkg::result_t            res;
    } row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          mass_limit_we;
    logic [sbf_pkg::LIMIT_W-1:0]   mass_limit;
    logic                          in_valid;
    logic                          in_stall;
    logic [sbf_pkg::IN_W-1:0]      weight;
    logic                          last_item;
    logic                          out_valid;
    logic                          out_stall;
    logic [sbf_pkg::INDEX_W-1:0]   item_index;
    logic [sbf_pkg::LIMIT_W-1:0]   best_sum;
    logic                          none_chosen;
    logic                          too_many;
    logic                          last_result;

    // predictor copy of the block state
    logic [sbf_pkg::IN_W-1:0]      held_w[CAP];
    int                            held_n;
    bit                            held_drop;
    logic [sbf_pkg::LIMIT_W-1:0]   limit_reg;
    int                            best_idx[CAP];
    int                            trial_idx[CAP];
    longint                        best_tot;
    int                            best_cnt;

    sbf_pkg::result_t   pending_q[$];
    sbf_pkg::result_t   fresh_q[$];
    int                 errors;
    int                 beats_sent;
    int                 results_seen;
    int                 sets_run;
    int                 burst_left;
    int                 idle_cycles;
    bit                 hold_req;
    bit                 accepted_any;

    row_t dir_rows[] = '{
        // after reset the limit is zero: nothing fits
        '{0, 20'd0,       16'd5,     1, 1, '{4'd0, 20'd0, 1'b1, 1'b0, 1'b1}},
        // widest limit, single full-scale weight
        '{1, 20'hFFFFF,   16'hFFFF,  1, 1, '{4'd0, 20'd65535, 1'b0, 1'b0, 1'b1}},
        // zero weight alone is never chosen
        '{0, 20'd0,       16'd0,     1, 1, '{4'd0, 20'd0, 1'b1, 1'b0, 1'b1}},
        // tie break and greedy bounds
        '{1, 20'd100,     16'd30,    0, 0, '{4'd0, 20'd0, 1'b0, 1'b0, 1'b0}},
        '{0, 20'd0,       16'd50,    0, 0, '{4'd0, 20'd0, 1'b0, 1'b0, 1'b0}},
        '{0, 20'd0,       16'd70,    0, 0, '{4'd0, 20'd0, 1'b0, 1'b0, 1'b0}},
        '{0, 20'd0,       16'd20,    1, 0, '{4'd0, 20'd0, 1'b0, 1'b0, 1'b0}},
        // zero weights mixed in
        '{0, 20'd0,       16'd0,     0, 0, '{4'd0, 20'd0, 1'b0, 1'b0, 1'b0}},
        '{0, 20'd0,       16'd40,    0, 0, '{4'd0, 20'd0, 1'b0, 1'b0, 1'b0}},
        '{0, 20'd0,       16'd0,     0, 0, '{4'd0, 20'd0, 1'b0, 1'b0, 1'b0}},
        '{0, 20'd0,       16'd60,    1, 0, '{4'd0, 20'd0, 1'b0, 1'b0, 1'b0}},
        // every weight above the limit
        '{1, 20'd10,      16'd11,    0, 0, '{4'd0, 20'd0, 1'b0, 1'b0, 1'b0}},
        '{0, 20'd0,       16'd12,    1, 1, '{4'd0, 20'd0, 1'b1, 1'b0, 1'b1}},
        // weight exactly at the limit
        '{0, 20'd0,       16'd10,    1, 1, '{4'd0, 20'd10, 1'b0, 1'b0, 1'b1}},
        // exact fit needs a mid-size subset
        '{1, 20'd21,      16'd8,     0, 0, '{4'd0, 20'd0, 1'b0, 1'b0, 1'b0}},
        '{0, 20'd0,       16'd7,     0, 0, '{4'd0, 20'd0, 1'b0, 1'b0, 1'b0}},
        '{0, 20'd0,       16'd13,    0, 0, '{4'd0, 20'd0, 1'b0, 1'b0, 1'b0}},
        '{0, 20'd0,       16'd6,     0, 0, '{4'd0, 20'd0, 1'b0, 1'b0, 1'b0}},
        '{0, 20'd0,       16'd14,    1, 0, '{4'd0, 20'd0, 1'b0, 1'b0, 1'b0}}
    };

    subset_sum_best_fit_search dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .mass_limit_we (mass_limit_we),
        .mass_limit    (mass_limit),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .weight        (weight),
        .last_item     (last_item),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .item_index    (item_index),
        .best_sum      (best_sum),
        .none_chosen   (none_chosen),
        .too_many      (too_many),
        .last_result   (last_result)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // mismatch report
    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // try every combination of size k in lexicographic order
    task automatic walk_size(input int n, input int k);
        int     j;
        longint sum;
        bit     done;
        if (k == 0 || k > n)
            return;
        for (j = 0; j < k; j++)
            trial_idx[j] = j;
        done = 0;
        while (!done)
        begin
            sum = 0;
            for (j = 0; j < k; j++)
                sum += longint'(held_w[trial_idx[j]]);
            if (sum > best_tot && sum <= longint'(limit_reg))
            begin
                best_tot = sum;
                best_cnt = k;
                for (j = 0; j < k; j++)
                    best_idx[j] = trial_idx[j];
            end
            j = k;
            while (j > 0 && trial_idx[j-1] >= n - k + (j - 1))
                j--;
            if (j == 0)
                done = 1;
            else
            begin
                trial_idx[j-1]++;
                for (; j < k; j++)
                    trial_idx[j] = trial_idx[j-1] + 1;
            end
        end
    endtask

    // load one weight; on the closing beat run the search into fresh_q
    task automatic absorb_weight(input logic [sbf_pkg::IN_W-1:0] w, input bit l);
        longint           srt[CAP];
        longint           v;
        longint           sum;
        int               i, j, k, upper, lower;
        sbf_pkg::result_t r;
        fresh_q.delete();
        if (held_n < CAP)
        begin
            held_w[held_n] = w;
            held_n++;
        end
        else
            held_drop = 1;
        if (!l)
            return;
        for (i = 0; i < held_n; i++)
            srt[i] = longint'(held_w[i]);
        for (i = 1; i < held_n; i++)
        begin
            v = srt[i];
            j = i;
            while (j > 0 && srt[j-1] > v)
            begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        upper = 0;
        sum   = 0;
        for (i = 0; i < held_n; i++)
        begin
            if (sum + srt[i] > longint'(limit_reg))
                break;
            sum += srt[i];
            upper++;
        end
        lower = 0;
        sum   = 0;
        for (i = held_n; i > 0; i--)
        begin
            if (sum + srt[i-1] <= longint'(limit_reg))
            begin
                sum += srt[i-1];
                lower++;
            end
        end
        best_tot = 0;
        best_cnt = 0;
        if (lower < 1)
            lower = 1;
        for (k = lower; k <= upper; k++)
            walk_size(held_n, k);
        if (best_cnt == 0)
        begin
            r = '{item_index: '0, best_sum: '0, none_chosen: 1'b1,
                  too_many: held_drop, last_result: 1'b1};
            fresh_q.push_back(r);
        end
        else
        begin
            for (i = 0; i < best_cnt; i++)
            begin
                r.item_index  = best_idx[i][sbf_pkg::INDEX_W-1:0];
                r.best_sum    = best_tot[sbf_pkg::LIMIT_W-1:0];
                r.none_chosen = 1'b0;
                r.too_many    = held_drop;
                r.last_result = (i + 1 == best_cnt);
                fresh_q.push_back(r);
            end
        end
        held_n    = 0;
        held_drop = 0;
        sets_run++;
    endtask

    // one input beat, entered at a falling edge and left at a falling edge
    task automatic send_beat(input logic [sbf_pkg::IN_W-1:0] w, input bit l, input bit typed,
                             input sbf_pkg::result_t typed_res);
        in_valid  <= 1'b1;
        weight    <= w;
        last_item <= l;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
        absorb_weight(w, l);
        if (typed && l)
            pending_q.push_back(typed_res);
        else
            foreach (fresh_q[i])
                pending_q.push_back(fresh_q[i]);
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(negedge clk);
            burst_left = $urandom_range(0, 12);
        end
        else
            burst_left--;
    endtask

    // drain the block, then write the limit while idle
    task automatic write_limit(input logic [sbf_pkg::LIMIT_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (20)
            @(negedge clk);
        mass_limit_we <= 1'b1;
        mass_limit    <= v;
        limit_reg      = v;
        @(negedge clk);
        mass_limit_we <= 1'b0;
    endtask

    // one random set, most weights scaled to the current limit
    task automatic send_random_set();
        int                       n, i;
        logic [sbf_pkg::IN_W-1:0] w;
        longint                   span;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 11) : $urandom_range(1, 6);
        span = longint'(limit_reg) / 3 + 1;
        if (span > 65535)
            span = 65535;
        for (i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 7))
                0:       w = '0;
                1, 2:    w = sbf_pkg::IN_W'($urandom());
                default: w = sbf_pkg::IN_W'($urandom_range(0, int'(span)));
            endcase
            send_beat(w, i == n - 1, 1'b0, '0);
        end
    endtask

    // receiver: random stall pattern plus one long hold-off on request
    initial
    begin
        int  run;
        bit  choppy;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (LONG_HOLD)
                    @(negedge clk);
                hold_req = 0;
            end
            choppy = $urandom_range(0, 1);
            run    = $urandom_range(5, 60);
            repeat (run)
            begin
                @(negedge clk);
                out_stall <= choppy ? ($urandom_range(0, 2) == 0) : 1'b0;
            end
        end
    end

    // result checker and idle watchdog
    always @(posedge clk)
    begin
        sbf_pkg::result_t want;
        accepted_any = (in_valid && !in_stall) || (out_valid && !out_stall);
        if (out_valid && !out_stall && rst_n)
        begin
            results_seen++;
            if (pending_q.size() == 0)
            begin
                report_mismatch("unexpected result beat, index", item_index, -1);
            end
            else
            begin
                want = pending_q.pop_front();
                if (item_index !== want.item_index)
                    report_mismatch("item_index", item_index, want.item_index);
                if (best_sum !== want.best_sum)
                    report_mismatch("best_sum", best_sum, want.best_sum);
                if (none_chosen !== want.none_chosen)
                    report_mismatch("none_chosen", none_chosen, want.none_chosen);
                if (too_many !== want.too_many)
                    report_mismatch("too_many", too_many, want.too_many);
                if (last_result !== want.last_result)
                    report_mismatch("last_result", last_result, want.last_result);
            end
        end
        idle_cycles = accepted_any ? 0 : idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles", HANG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int i, ph;
        logic [sbf_pkg::LIMIT_W-1:0] phase_lim;
        rst_n         = 1'b0;
        mass_limit_we = 1'b0;
        mass_limit    = '0;
        in_valid      = 1'b0;
        weight        = '0;
        last_item     = 1'b0;
        hold_req      = 0;
        errors        = 0;
        beats_sent    = 0;
        results_seen  = 0;
        sets_run      = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        held_n        = 0;
        held_drop     = 0;
        limit_reg     = '0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].cfg)
                write_limit(dir_rows[r].lim);
            send_beat(dir_rows[r].w, dir_rows[r].l, dir_rows[r].typed, dir_rows[r].res);
        end

        // over capacity: 17 full-scale weights, all 16 stored ones fit
        write_limit(20'hFFFFF);
        for (i = 0; i < CAP + 1; i++)
            send_beat(16'hFFFF, i == CAP, 1'b0, '0);

        // random sets across several limits, long receiver hold-off at the start
        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:       phase_lim = sbf_pkg::LIMIT_W'($urandom_range(50000, 300000));
                1:       phase_lim = 20'hFFFFF;
                2:       phase_lim = sbf_pkg::LIMIT_W'($urandom_range(1, 2000));
                3:       phase_lim = sbf_pkg::LIMIT_W'($urandom());
                default: phase_lim = '0;
            endcase
            write_limit(phase_lim);
            if (ph == 0)
                hold_req = 1;
            while (beats_sent < 36 + (ph + 1) * 75)
                send_random_set();
        end
        in_valid <= 1'b0;

        // drain and finish
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (50)
            @(negedge clk);
        $display("Covered %0d weight beats in %0d searches, %0d result beats checked,",
                 beats_sent, sets_run, results_seen);
        $display("limits from zero to full scale, capacity overflow and receiver hold-off.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
